### hw/rtl/csrmv_pkg.sv
// Shared types, item codes and limits for the CSR sparse matrix-vector MAC.
// No dependencies; imported by csrmv_accum and csr_sparse_matrix_vector_mac.
package csrmv_pkg;

    // field widths
    localparam int FUNC_W = 2;
    localparam int POS_W  = 10;
    localparam int VAL_W  = 32;
    localparam int ROW_W  = 16;
    localparam int SUM_W  = 64;

    // default depth of the dense vector store
    localparam int VECTOR_DEPTH_DEF = 1024;

    // item kinds
    localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_NONZERO = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_EMPTY   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd3;

    // saturation limits of the Q32.32 row sum
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // one operation handed to the accumulator
    typedef struct packed {
        logic              go;
        logic [FUNC_W-1:0] func;
        logic              row_end;
    } t_acc_op;

    // a finished row from the accumulator
    typedef struct packed {
        logic                    emit;
        logic [ROW_W-1:0]        row_number;
        logic signed [SUM_W-1:0] row_sum;
        logic                    saturated;
    } t_row_result;

endpackage

### hw/rtl/csr_sparse_matrix_vector_mac.sv
// CSR sparse matrix-vector MAC: dense vector store, multiply stage and row accumulator.
// The item that ends a row passes stage 1 and stage 2; its result beat then sits in the
// output register. Throughput: one item per cycle while o_stall is low; set by the
// saturating add loop and the vector store read per item, made at the accept edge.
// Reset clears pipeline valids, sum, flag and row count; vector store is not cleared.
// Depends on csrmv_pkg and csrmv_accum.
module csr_sparse_matrix_vector_mac
    import csrmv_pkg::*;
#(
    parameter int VECTOR_DEPTH = VECTOR_DEPTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [FUNC_W-1:0]       i_func,
    input  logic [POS_W-1:0]        i_position,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic                    i_row_end,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [ROW_W-1:0]        o_row_number,
    output logic signed [SUM_W-1:0] o_row_sum,
    output logic                    o_saturated
);

    localparam int AW    = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
    localparam int EXT_W = 17;

    // vector store and its registered read port
    logic [VAL_W-1:0] r_vec [VECTOR_DEPTH];
    logic [VAL_W-1:0] r_rdata;

    // stage 1: item waiting for its vector element
    logic                    r1_valid;
    logic [FUNC_W-1:0]       r1_func;
    logic signed [VAL_W-1:0] r1_value;
    logic                    r1_row_end;
    logic                    r1_in_range;

    // stage 2: product ready for accumulation
    logic                    r2_valid;
    logic [FUNC_W-1:0]       r2_func;
    logic                    r2_row_end;
    logic signed [SUM_W-1:0] r2_prod;

    // output register
    logic                    r_out_valid;
    logic [ROW_W-1:0]        r_out_row;
    logic signed [SUM_W-1:0] r_out_sum;
    logic                    r_out_sat;

    logic [EXT_W-1:0]        pos_ext;
    logic [AW-1:0]           addr;
    logic                    in_range;
    logic                    accept;
    logic                    out_free;
    logic                    r2_emits;
    logic                    s2_go;
    logic                    s1_go;
    logic signed [VAL_W-1:0] rdata_s;
    logic signed [SUM_W-1:0] mul_full;
    t_acc_op                 acc_op;
    t_row_result             acc_res;

    // address decode and range check
    assign pos_ext  = EXT_W'(i_position);
    assign addr     = pos_ext[AW-1:0];
    assign in_range = pos_ext < EXT_W'(VECTOR_DEPTH);

    // per-stage flow: a stage moves when the slot after it is free or moving
    assign out_free = !r_out_valid || !i_stall;
    assign r2_emits = (r2_func == FUNC_NONZERO && r2_row_end) || (r2_func == FUNC_EMPTY);
    assign s2_go    = !r2_valid || !r2_emits || out_free;
    assign s1_go    = !r2_valid || s2_go;
    assign o_stall  = r1_valid && !s1_go;
    assign accept   = i_valid && !o_stall;

    // vector store: write on an in-range load, read for every accepted item
    always_ff @(posedge i_clk) begin
        if (accept && i_func == FUNC_LOAD && in_range) begin
            r_vec[addr] <= i_value;
        end
        if (accept) begin
            r_rdata <= r_vec[addr];
        end
    end

    // stage 1 register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (!o_stall) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_func     <= i_func;
            r1_value    <= i_value;
            r1_row_end  <= i_row_end;
            r1_in_range <= in_range;
        end
    end

    // Q16.16 x Q16.16 is exact in Q32.32; operands sign-extend to the 64-bit context
    assign rdata_s  = $signed(r_rdata);
    assign mul_full = r1_value * rdata_s;

    // stage 2 register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (s1_go) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r1_valid) begin
            r2_func    <= r1_func;
            r2_row_end <= r1_row_end;
            r2_prod    <= r1_in_range ? mul_full : '0;
        end
    end

    // accumulation
    assign acc_op.go      = r2_valid && s2_go;
    assign acc_op.func    = r2_func;
    assign acc_op.row_end = r2_row_end;

    csrmv_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (acc_op),
        .i_prod  (r2_prod),
        .o_res   (acc_res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= acc_res.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_res.emit) begin
            r_out_row <= acc_res.row_number;
            r_out_sum <= acc_res.row_sum;
            r_out_sat <= acc_res.saturated;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_row_number = r_out_row;
    assign o_row_sum    = r_out_sum;
    assign o_saturated  = r_out_sat;

`ifndef ASSERT_OFF
    // held stage 1 keeps its vector element
    a_rdata_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r1_valid && !s1_go) |=> $stable(r_rdata))
        else $error("vector read data changed under a held item");

    // held stage 1 keeps its item
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r1_valid && !s1_go) |=> (r1_valid && $stable(r1_value) && $stable(r1_func)))
        else $error("stage 1 item lost while held");

    // an empty output register never back-pressures the input
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> !o_stall)
        else $error("input stalled with output register empty");
`endif

endmodule

### hw/rtl/csrmv_accum.sv
// Row accumulator: saturating Q32.32 add, overflow flag and row counter.
// Depends on csrmv_pkg for item codes, limits and the t_acc_op/t_row_result types.
module csrmv_accum
    import csrmv_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_acc_op                 i_op,
    input  logic signed [SUM_W-1:0] i_prod,
    output t_row_result             o_res
);

    logic signed [SUM_W-1:0] r_acc, n_acc;
    logic                    r_ovf, n_ovf;
    logic [ROW_W-1:0]        r_row, n_row;

    logic signed [SUM_W-1:0] add_raw;
    logic signed [SUM_W-1:0] add_sat;
    logic                    add_ovf;

    // saturating add of the product into the running sum
    always_comb begin
        add_raw = r_acc + i_prod;
        add_ovf = (r_acc[SUM_W-1] == i_prod[SUM_W-1]) &&
                  (add_raw[SUM_W-1] != r_acc[SUM_W-1]);
        if (add_ovf) begin
            add_sat = r_acc[SUM_W-1] ? SUM_MIN : SUM_MAX;
        end else begin
            add_sat = add_raw;
        end
    end

    // next state and finished-row beat
    always_comb begin
        n_acc = r_acc;
        n_ovf = r_ovf;
        n_row = r_row;
        o_res.emit       = 1'b0;
        o_res.row_number = r_row;
        o_res.row_sum    = r_acc;
        o_res.saturated  = r_ovf;
        if (i_op.go) begin
            unique case (i_op.func)
                FUNC_NONZERO: begin
                    o_res.row_sum   = add_sat;
                    o_res.saturated = r_ovf | add_ovf;
                    if (i_op.row_end) begin
                        o_res.emit = 1'b1;
                        n_acc = '0;
                        n_ovf = 1'b0;
                        n_row = r_row + 1'b1;
                    end else begin
                        n_acc = add_sat;
                        n_ovf = r_ovf | add_ovf;
                    end
                end
                FUNC_EMPTY: begin
                    o_res.emit = 1'b1;
                    n_acc = '0;
                    n_ovf = 1'b0;
                    n_row = r_row + 1'b1;
                end
                FUNC_RESTART: begin
                    n_acc = '0;
                    n_ovf = 1'b0;
                    n_row = '0;
                end
                FUNC_LOAD: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_ovf <= 1'b0;
            r_row <= '0;
        end else begin
            r_acc <= n_acc;
            r_ovf <= n_ovf;
            r_row <= n_row;
        end
    end

`ifndef ASSERT_OFF
    // restart leaves a clean sum, flag and row count
    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op.go && i_op.func == FUNC_RESTART) |=> (r_acc == '0 && !r_ovf && r_row == '0))
        else $error("restart did not clear accumulator state");

    // each finished row advances the row number by exactly one
    a_row_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.emit |=> (r_row == $past(r_row) + 1'b1))
        else $error("row number did not advance after a finished row");

    // a finished row always starts the next one from zero
    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.emit |=> (r_acc == '0 && !r_ovf))
        else $error("sum or flag not cleared after a finished row");
`endif

endmodule
